@@ design/iir_direct_form_one_filter_macros.svh @@
// ----------------------------------------------------------------------------
// IIR direct form I filter assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef IIR_DIRECT_FORM_ONE_FILTER_MACROS_SVH
`define IIR_DIRECT_FORM_ONE_FILTER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define IIRDF1_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define IIRDF1_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/iirdf1_pkg.sv @@
// ----------------------------------------------------------------------------
// IIR direct form I filter package
// Widths, register indexes, reset values and shared types.
// ----------------------------------------------------------------------------
package iirdf1_pkg;

    // Default filter order and coefficient fraction bits
    localparam int ORDER_DEF          = 3;
    localparam int COEF_FRAC_BITS_DEF = 14;

    // Sample and coefficient widths
    localparam int SAMPLE_W = 16;
    localparam int COEF_W   = 16;
    localparam int PROD_W   = SAMPLE_W + COEF_W;
    localparam int TERM_W   = PROD_W + 1;
    // Seven products of up to 2^30 each fit in 34 bits; keep one spare
    localparam int ACC_W    = PROD_W + 3;

    // Configuration register indexes
    localparam int NUM_REGS = 7;
    localparam int IDX_W    = 3;

    typedef enum logic [IDX_W-1:0] {
        REG_FEED_0,
        REG_FEED_1,
        REG_FEED_2,
        REG_FEED_3,
        REG_BACK_1,
        REG_BACK_2,
        REG_BACK_3
    } reg_idx_t;

    // b0 resets to 1.0 in Q2.14
    localparam logic signed [COEF_W-1:0] FEED_0_RESET = 16'sd16384;

    // Configuration write bundle handed to every tap cell
    typedef struct packed {
        logic                en;
        logic [IDX_W-1:0]    index;
        logic [COEF_W-1:0]   data;
    } cfg_wr_t;

endpackage

@@ design/iirdf1_cell.sv @@
// ----------------------------------------------------------------------------
// IIR direct form I tap cell
// Holds one input and one output history word plus the matching feedforward
// and feedback coefficients; forms b*x - a*y and shifts history onward.
// ----------------------------------------------------------------------------
module iirdf1_cell #(
    parameter int TAP = 1
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  iirdf1_pkg::cfg_wr_t                       wr,
    input  logic                                      shift,
    input  logic signed [iirdf1_pkg::SAMPLE_W-1:0]    x_prev,
    input  logic signed [iirdf1_pkg::SAMPLE_W-1:0]    y_prev,
    output logic signed [iirdf1_pkg::SAMPLE_W-1:0]    x_hist,
    output logic signed [iirdf1_pkg::SAMPLE_W-1:0]    y_hist,
    output logic signed [iirdf1_pkg::TERM_W-1:0]      term
);

    localparam logic [iirdf1_pkg::IDX_W-1:0] FEED_IDX =
        iirdf1_pkg::IDX_W'(int'(iirdf1_pkg::REG_FEED_0) + TAP);
    localparam logic [iirdf1_pkg::IDX_W-1:0] BACK_IDX =
        iirdf1_pkg::IDX_W'(int'(iirdf1_pkg::REG_BACK_1) + TAP - 1);

    logic signed [iirdf1_pkg::COEF_W-1:0]   feed_reg;
    logic signed [iirdf1_pkg::COEF_W-1:0]   back_reg;
    logic signed [iirdf1_pkg::SAMPLE_W-1:0] x_reg;
    logic signed [iirdf1_pkg::SAMPLE_W-1:0] y_reg;
    logic signed [iirdf1_pkg::PROD_W-1:0]   feed_prod;
    logic signed [iirdf1_pkg::PROD_W-1:0]   back_prod;

    // Load coefficients from the configuration port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            feed_reg <= '0;
            back_reg <= '0;
        end
        else if (wr.en)
        begin
            if (wr.index == FEED_IDX)
            begin
                feed_reg <= wr.data;
            end
            if (wr.index == BACK_IDX)
            begin
                back_reg <= wr.data;
            end
        end
    end

    // Advance history from the neighbor on each accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg <= '0;
            y_reg <= '0;
        end
        else if (shift)
        begin
            x_reg <= x_prev;
            y_reg <= y_prev;
        end
    end

    // Form this tap's contribution
    always_comb
    begin
        feed_prod = feed_reg * x_reg;
        back_prod = back_reg * y_reg;
        term      = iirdf1_pkg::TERM_W'(feed_prod) - iirdf1_pkg::TERM_W'(back_prod);
    end

    assign x_hist = x_reg;
    assign y_hist = y_reg;

endmodule

@@ design/iir_direct_form_one_filter.sv @@
// Direct form I IIR filter, one 16-bit sample in and one 16-bit sample out
// per cycle unless out_ready stalls; output is valid in the cycle after input
// accept. The rate is set by the feedback path: the new output feeds the first
// history cell in the same cycle it is formed, so all 2*ORDER+1 16x16
// multipliers, the adder, the floor shift by COEF_FRAC_BITS and the 16-bit
// saturation sit between the history registers and the output register.
// Coefficients are Q2.14 and may be written only while the filter is idle.
// ----------------------------------------------------------------------------
// IIR direct form I filter top level
// Chain of tap cells, b0 product, sum, floor shift, saturate, output register.
// ----------------------------------------------------------------------------
`include "iir_direct_form_one_filter_macros.svh"

module iir_direct_form_one_filter #(
    parameter int ORDER          = iirdf1_pkg::ORDER_DEF,
    parameter int COEF_FRAC_BITS = iirdf1_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      wr_en,
    input  logic [iirdf1_pkg::IDX_W-1:0]              wr_index,
    input  logic [iirdf1_pkg::COEF_W-1:0]             wr_data,
    input  logic                                      in_valid,
    output logic                                      in_ready,
    input  logic signed [iirdf1_pkg::SAMPLE_W-1:0]    sample_in,
    output logic                                      out_valid,
    input  logic                                      out_ready,
    output logic signed [iirdf1_pkg::SAMPLE_W-1:0]    sample_out,
    output logic                                      clipped
);

    localparam int ACC_W = iirdf1_pkg::ACC_W;
    localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] SAT_MIN = -ACC_W'(32768);

    iirdf1_pkg::cfg_wr_t wr;
    logic                in_fire;

    logic signed [iirdf1_pkg::COEF_W-1:0]   feed0_reg;
    logic signed [iirdf1_pkg::PROD_W-1:0]   feed0_prod;

    logic signed [iirdf1_pkg::SAMPLE_W-1:0] x_hist [1:ORDER];
    logic signed [iirdf1_pkg::SAMPLE_W-1:0] y_hist [1:ORDER];
    logic signed [iirdf1_pkg::TERM_W-1:0]   term   [1:ORDER];

    logic signed [ACC_W-1:0]                acc;
    logic signed [ACC_W-1:0]                shifted;
    logic signed [iirdf1_pkg::SAMPLE_W-1:0] y_new;
    logic                                   clip_new;

    logic                                   valid_reg;
    logic signed [iirdf1_pkg::SAMPLE_W-1:0] sample_reg;
    logic                                   clip_reg;

    assign wr.en    = wr_en;
    assign wr.index = wr_index;
    assign wr.data  = wr_data;

    // Take a new word whenever the output register is free or being drained
    assign in_ready = !valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    // Hold b0 locally; it multiplies the incoming sample directly
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            feed0_reg <= iirdf1_pkg::FEED_0_RESET;
        end
        else if (wr_en && wr_index == iirdf1_pkg::REG_FEED_0)
        begin
            feed0_reg <= wr_data;
        end
    end

    // Chain of history cells, one per tap
    for (genvar t = 1; t <= ORDER; t++)
    begin : g_cell
        logic signed [iirdf1_pkg::SAMPLE_W-1:0] x_src;
        logic signed [iirdf1_pkg::SAMPLE_W-1:0] y_src;

        if (t == 1)
        begin : g_head
            assign x_src = sample_in;
            assign y_src = y_new;
        end
        else
        begin : g_body
            assign x_src = x_hist[t-1];
            assign y_src = y_hist[t-1];
        end

        iirdf1_cell #(
            .TAP (t)
        ) u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .wr     (wr),
            .shift  (in_fire),
            .x_prev (x_src),
            .y_prev (y_src),
            .x_hist (x_hist[t]),
            .y_hist (y_hist[t]),
            .term   (term[t])
        );
    end

    // Sum taps, floor shift, saturate
    always_comb
    begin
        feed0_prod = feed0_reg * sample_in;
        acc        = ACC_W'(feed0_prod);
        for (int t = 1; t <= ORDER; t++)
        begin
            acc = acc + ACC_W'(term[t]);
        end
        shifted = acc >>> COEF_FRAC_BITS;
        if (shifted > SAT_MAX)
        begin
            y_new    = 16'sh7fff;
            clip_new = 1'b1;
        end
        else if (shifted < SAT_MIN)
        begin
            y_new    = 16'sh8000;
            clip_new = 1'b1;
        end
        else
        begin
            y_new    = shifted[iirdf1_pkg::SAMPLE_W-1:0];
            clip_new = 1'b0;
        end
    end

    // Output register: load on accept, drop valid once drained
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            sample_reg <= y_new;
            clip_reg   <= clip_new;
        end
    end

    assign out_valid  = valid_reg;
    assign sample_out = sample_reg;
    assign clipped    = clip_reg;

    // Checks on the datapath and output register
    `IIRDF1_ASSERT_NEXT(a_fire_gives_word, in_fire, valid_reg, "accepted word did not appear")
    `IIRDF1_ASSERT_NEXT(a_xhist_loads, in_fire, x_hist[1] == $past(sample_in), "x history slip")
    `IIRDF1_ASSERT_NOW(a_yhist_matches, valid_reg, y_hist[1] == sample_reg, "y feedback mismatch")
    `IIRDF1_ASSERT_NOW(a_clip_rails, valid_reg && clip_reg, sample_reg == 16'sh7fff || sample_reg == 16'sh8000, "clip off rail")
    `IIRDF1_ASSERT_NEXT(a_hist_hold, !in_fire, $stable(x_hist[1]) && $stable(y_hist[1]), "history moved")

endmodule
